[sv/ohci_rb_pkg.sv]
// Shared types, constants and reset values of the OHCI host register block.
package ohci_rb_pkg;

    localparam int NUM_PORTS = 2;
    localparam int NUM_WORDS = 24;
    localparam int IDX_W     = $clog2(NUM_WORDS);
    localparam int CNT_W     = 19;

    localparam logic [11:0] AP_END = 12'h060;

    localparam logic [IDX_W-1:0] W_REV   = IDX_W'(0);
    localparam logic [IDX_W-1:0] W_CTRL  = IDX_W'(1);
    localparam logic [IDX_W-1:0] W_CMD   = IDX_W'(2);
    localparam logic [IDX_W-1:0] W_ISTAT = IDX_W'(3);
    localparam logic [IDX_W-1:0] W_IEN   = IDX_W'(4);
    localparam logic [IDX_W-1:0] W_IDIS  = IDX_W'(5);
    localparam logic [IDX_W-1:0] W_FMINT = IDX_W'(13);
    localparam logic [IDX_W-1:0] W_FMREM = IDX_W'(14);
    localparam logic [IDX_W-1:0] W_FMNUM = IDX_W'(15);
    localparam logic [IDX_W-1:0] W_PSTRT = IDX_W'(16);
    localparam logic [IDX_W-1:0] W_LSTHR = IDX_W'(17);
    localparam logic [IDX_W-1:0] W_RHDA  = IDX_W'(18);
    localparam logic [IDX_W-1:0] W_PORT0 = IDX_W'(21);

    localparam logic [31:0] RST_REV   = 32'h0000_0010;
    localparam logic [31:0] RST_FMINT = 32'h2778_2EDF;
    localparam logic [31:0] RST_PSTRT = 32'h0000_3E67;
    localparam logic [31:0] RST_LSTHR = 32'h0000_0628;
    localparam logic [31:0] RHDA_FIX  = 32'h0000_00FF;
    localparam logic [31:0] RHDA_RST  = 32'h0000_0200 | (32'(NUM_PORTS) & RHDA_FIX);
    localparam logic [31:0] CTRL_CLR  = 32'h0000_00C0;
    localparam logic [31:0] HALF_HI   = 32'hFFFF_0000;

    localparam logic [31:0] P_CCS  = 32'h0000_0001;
    localparam logic [31:0] P_PES  = 32'h0000_0002;
    localparam logic [31:0] P_PPS  = 32'h0000_0100;
    localparam logic [31:0] P_CSC  = 32'h0001_0000;
    localparam logic [31:0] P_PRSC = 32'h0010_0000;
    localparam logic [31:0] I_RHSC = 32'h0000_0040;

    localparam logic [1:0] RST_MASK = 2'd1;
    localparam logic [9:0] FRM_MUL  = 10'd977;
    localparam logic [13:0] FRM_REM_M = 14'h3FFF;

    localparam logic [1:0] AW_BYTE = 2'd0;
    localparam logic [1:0] AW_HALF = 2'd1;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic        op;
        logic [11:0] off;
        logic [1:0]  wd;
        logic [31:0] data;
    } t_txn;

    function automatic logic [31:0] f_init_word(logic [IDX_W-1:0] idx, logic [1:0] mask);
        logic [31:0] w;
        w = '0;
        unique case (idx)
            W_REV:   w = RST_REV;
            W_FMINT: w = RST_FMINT;
            W_PSTRT: w = RST_PSTRT;
            W_LSTHR: w = RST_LSTHR;
            W_RHDA:  w = RHDA_RST;
            default: w = '0;
        endcase
        for (int p = 0; p < NUM_PORTS; p++) begin
            if (idx == W_PORT0 + IDX_W'(p)) begin
                w = P_PPS | (mask[p] ? (P_CCS | P_CSC) : 32'h0);
            end
            if (idx == W_ISTAT && mask[p]) begin
                w = I_RHSC;
            end
        end
        return w;
    endfunction

    function automatic logic f_inside(logic [11:0] off);
        return off < AP_END;
    endfunction

endpackage

[sv/ohci_rb_in_stage.sv]
// Input register: captures one bus transaction per cycle.
module ohci_rb_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  ohci_rb_pkg::t_txn  i_txn,
    output logic               o_vld,
    output ohci_rb_pkg::t_txn  o_txn
);

    logic              r_vld;
    ohci_rb_pkg::t_txn r_txn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_txn <= i_txn;
        end
    end

    assign o_vld = r_vld;
    assign o_txn = r_txn;

endmodule

[sv/ohci_rb_regs.sv]
// Operational register words with their per-register write rules.
module ohci_rb_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  ohci_rb_pkg::t_txn  i_txn,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_wdata,
    output logic [31:0]        o_rd_word
);

    logic [31:0] r_word [ohci_rb_pkg::NUM_WORDS];
    logic [31:0] n_word [ohci_rb_pkg::NUM_WORDS];

    logic                          init;
    logic [1:0]                    init_mask;
    logic                          in_ap;
    logic [ohci_rb_pkg::IDX_W-1:0] w;
    logic [4:0]                    shift;
    logic [31:0]                   v;
    logic [31:0]                   m;
    logic [31:0]                   cmd;
    logic [31:0]                   ps;
    logic                          wr;
    logic                          is_port;
    logic                          wr_port_rst;

    assign init      = !i_rst_n || i_cfg_we;
    assign init_mask = !i_rst_n ? ohci_rb_pkg::RST_MASK : i_cfg_wdata;
    assign in_ap     = ohci_rb_pkg::f_inside(i_txn.off);
    assign w         = i_txn.off[ohci_rb_pkg::IDX_W+1:2];
    assign shift     = {i_txn.off[1:0], 3'b000};
    assign v         = i_txn.data;
    assign wr        = i_vld && (i_txn.op == ohci_rb_pkg::OP_WRITE) && in_ap;
    assign is_port   = (w >= ohci_rb_pkg::W_PORT0)
                    && (w < ohci_rb_pkg::W_PORT0 + ohci_rb_pkg::IDX_W'(ohci_rb_pkg::NUM_PORTS));
    assign wr_port_rst = wr && is_port && v[4];

    always_comb begin
        o_rd_word = '0;
        if (in_ap) begin
            o_rd_word = r_word[w];
        end
    end

    always_comb begin
        n_word = r_word;
        cmd    = r_word[ohci_rb_pkg::W_CMD] | v;
        ps     = '0;
        m      = '0;
        if (init) begin
            for (int i = 0; i < ohci_rb_pkg::NUM_WORDS; i++) begin
                n_word[i] = ohci_rb_pkg::f_init_word(ohci_rb_pkg::IDX_W'(i), init_mask);
            end
        end else if (wr) begin
            priority if (w == ohci_rb_pkg::W_REV || w == ohci_rb_pkg::W_FMNUM
                         || w == ohci_rb_pkg::W_FMREM) begin
                n_word = r_word;
            end else if (w == ohci_rb_pkg::W_CMD) begin
                if (cmd[0]) begin
                    n_word[ohci_rb_pkg::W_CMD]   = cmd & ~32'h1;
                    n_word[ohci_rb_pkg::W_CTRL]  = r_word[ohci_rb_pkg::W_CTRL]
                                                 & ~ohci_rb_pkg::CTRL_CLR;
                    n_word[ohci_rb_pkg::W_ISTAT] = '0;
                    n_word[ohci_rb_pkg::W_IEN]   = '0;
                end else begin
                    n_word[ohci_rb_pkg::W_CMD] = cmd;
                end
            end else if (w == ohci_rb_pkg::W_ISTAT) begin
                n_word[ohci_rb_pkg::W_ISTAT] = r_word[ohci_rb_pkg::W_ISTAT] & ~v;
            end else if (w == ohci_rb_pkg::W_IEN) begin
                n_word[ohci_rb_pkg::W_IEN] = r_word[ohci_rb_pkg::W_IEN] | v;
            end else if (w == ohci_rb_pkg::W_IDIS) begin
                n_word[ohci_rb_pkg::W_IEN] = r_word[ohci_rb_pkg::W_IEN] & ~v;
            end else if (w == ohci_rb_pkg::W_RHDA) begin
                n_word[ohci_rb_pkg::W_RHDA] = (r_word[ohci_rb_pkg::W_RHDA] & ohci_rb_pkg::RHDA_FIX)
                                            | (v & ~ohci_rb_pkg::RHDA_FIX);
            end else if (is_port) begin
                ps = r_word[w];
                if (v[0]) begin
                    ps = ps & ~ohci_rb_pkg::P_PES;
                end
                if (v[1] && ps[0]) begin
                    ps = ps | ohci_rb_pkg::P_PES;
                end
                if (v[8]) begin
                    ps = ps | ohci_rb_pkg::P_PPS;
                end
                if (v[9]) begin
                    ps = ps & ~ohci_rb_pkg::P_PPS;
                end
                if (v[4]) begin
                    if (ps[0]) begin
                        ps = ps | ohci_rb_pkg::P_PES;
                    end
                    ps = ps | ohci_rb_pkg::P_PRSC;
                    n_word[ohci_rb_pkg::W_ISTAT] = r_word[ohci_rb_pkg::W_ISTAT]
                                                 | ohci_rb_pkg::I_RHSC;
                end
                n_word[w] = ps & ~(v & ohci_rb_pkg::HALF_HI);
            end else if (i_txn.wd == ohci_rb_pkg::AW_BYTE
                         || i_txn.wd == ohci_rb_pkg::AW_HALF) begin
                m = ((i_txn.wd == ohci_rb_pkg::AW_BYTE) ? 32'h0000_00FF : 32'h0000_FFFF) << shift;
                n_word[w] = (r_word[w] & ~m) | ((v << shift) & m);
            end else begin
                n_word[w] = v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    a_cmd_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_word[ohci_rb_pkg::W_CMD][0])
        else $error("host reset bit left set");

    a_rhda_low_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word[ohci_rb_pkg::W_RHDA][7:0] == 8'(ohci_rb_pkg::NUM_PORTS))
        else $error("descriptor A low byte changed");

    a_rev_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word[ohci_rb_pkg::W_REV] == ohci_rb_pkg::RST_REV)
        else $error("revision word changed");

    a_port_rst_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !i_cfg_we && wr_port_rst) |=> r_word[ohci_rb_pkg::W_ISTAT][6])
        else $error("port reset did not raise root hub status change");

endmodule

[sv/ohci_rb_rd_path.sv]
// Read counter, frame register derivation, slicing and result register.
module ohci_rb_rd_path (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  ohci_rb_pkg::t_txn  i_txn,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_rd_word,
    output logic               o_strobe,
    output logic [31:0]        o_read_data
);

    logic [ohci_rb_pkg::CNT_W-1:0] r_cnt;
    logic [ohci_rb_pkg::CNT_W-1:0] n_cnt;
    logic                          r_strobe;
    logic [31:0]                   r_rdata;
    logic [31:0]                   n_rdata;

    logic                          rd;
    logic                          in_ap;
    logic [ohci_rb_pkg::IDX_W-1:0] w;
    logic [4:0]                    shift;
    logic [23:0]                   prod;
    logic [31:0]                   word;
    logic [31:0]                   sh;

    assign rd    = i_vld && (i_txn.op == ohci_rb_pkg::OP_READ);
    assign in_ap = ohci_rb_pkg::f_inside(i_txn.off);
    assign w     = i_txn.off[ohci_rb_pkg::IDX_W+1:2];
    assign shift = {i_txn.off[1:0], 3'b000};
    assign n_cnt = rd ? r_cnt + ohci_rb_pkg::CNT_W'(1) : r_cnt;
    assign prod  = 24'(n_cnt[13:0]) * 24'(ohci_rb_pkg::FRM_MUL);

    always_comb begin
        word = i_rd_word;
        if (in_ap && w == ohci_rb_pkg::W_FMNUM) begin
            word = 32'(n_cnt[18:3]);
        end else if (in_ap && w == ohci_rb_pkg::W_FMREM) begin
            word = 32'(prod[13:0] & ohci_rb_pkg::FRM_REM_M);
        end
        sh = word >> shift;
        priority if (i_txn.wd == ohci_rb_pkg::AW_BYTE) begin
            n_rdata = sh & 32'h0000_00FF;
        end else if (i_txn.wd == ohci_rb_pkg::AW_HALF) begin
            n_rdata = sh & 32'h0000_FFFF;
        end else begin
            n_rdata = word;
        end
        if (!rd) begin
            n_rdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_vld;
        end
        if (i_vld) begin
            r_rdata <= n_rdata;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_read_data = r_rdata;

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !i_cfg_we && rd) |=> r_cnt == $past(r_cnt) + ohci_rb_pkg::CNT_W'(1))
        else $error("read counter did not advance");

    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !i_cfg_we && !rd) |=> $stable(r_cnt))
        else $error("read counter moved without a read");

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_vld) |=> r_strobe)
        else $error("transaction produced no result");

endmodule

[sv/ohci_rb_top.sv]
// Top level of the OHCI host register block.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+---------------------------------------------
//  request  | in        | start, busy           | i_op, i_byte_offset, i_access_width, i_write_data
//  result   | out       | o_strobe (one cycle)  | o_read_data
//  config   | in        | i_cfg_we              | i_cfg_wdata
//
//  One transaction per cycle; busy stays low. An accepted transaction is held in the input
//  register, then the register-file update and the result register load happen in a single
//  pass; the result is on the ports once the result register has loaded.
//  Reset (synchronous, active low) and a config write both restore the register
//  words and clear the read counter; the config write also sets the connect mask.
//  The receiver cannot stall: o_strobe marks each result for exactly one cycle.
module ohci_host_register_block_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [11:0] i_byte_offset,
    input  logic [1:0]  i_access_width,
    input  logic [31:0] i_write_data,
    output logic        o_strobe,
    output logic [31:0] o_read_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata
);

    ohci_rb_pkg::t_txn in_txn;
    ohci_rb_pkg::t_txn st_txn;
    logic              st_vld;
    logic              take;
    logic [31:0]       rd_word;

    assign busy = 1'b0;
    assign take = start && !busy;

    assign in_txn.op   = i_op;
    assign in_txn.off  = i_byte_offset;
    assign in_txn.wd   = i_access_width;
    assign in_txn.data = i_write_data;

    ohci_rb_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_txn   (in_txn),
        .o_vld   (st_vld),
        .o_txn   (st_txn)
    );

    ohci_rb_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (st_vld),
        .i_txn       (st_txn),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_rd_word   (rd_word)
    );

    ohci_rb_rd_path u_rd (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (st_vld),
        .i_txn       (st_txn),
        .i_cfg_we    (i_cfg_we),
        .i_rd_word   (rd_word),
        .o_strobe    (o_strobe),
        .o_read_data (o_read_data)
    );

endmodule
